FILE: rtl/perceptron_point_trainer_macros.svh
// assertion helpers shared by the rtl files
`ifndef PERCEPTRON_POINT_TRAINER_MACROS_SVH
`define PERCEPTRON_POINT_TRAINER_MACROS_SVH
`ifndef SYNTH
`define PPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PPT_ASSERT_NEVER(lbl, cond, msg) \
  `PPT_ASSERT(lbl, !(cond), msg)
`else
`define PPT_ASSERT(lbl, prop, msg)
`define PPT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

  localparam int DEF_NUM_WEIGHTS = 3;

  localparam int RATE_W  = 16;
  localparam int W_W     = 32;
  localparam int C_W     = 16;
  localparam int CNT_W   = 16;
  localparam int MUL_A_W = W_W + 1;
  localparam int PROD_W  = MUL_A_W + C_W;
  localparam int STEP_W  = 25;
  localparam int ADDR_W  = 3;

  localparam logic [ADDR_W-1:0] REG_LEARN_RATE  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_INIT_A      = 3'd1;
  localparam logic [ADDR_W-1:0] REG_INIT_B      = 3'd2;
  localparam logic [ADDR_W-1:0] REG_INIT_C      = 3'd3;
  localparam logic [ADDR_W-1:0] REG_MAX_UPDATES = 3'd4;

  localparam logic [RATE_W-1:0] RST_LEARN_RATE  = 16'd6554;
  localparam logic [CNT_W-1:0]  RST_MAX_UPDATES = 16'd1024;

  localparam logic [W_W-1:0] W_MAX = 32'h7fff_ffff;
  localparam logic [W_W-1:0] W_MIN = 32'h8000_0000;

  typedef struct packed {
    logic             restart;
    logic             label;
    logic [C_W-1:0]   coord_c;
    logic [C_W-1:0]   coord_b;
    logic [C_W-1:0]   coord_a;
  } item_t;

  typedef struct packed {
    logic [RATE_W-1:0] learn_rate;
    logic [W_W-1:0]    init_a;
    logic [W_W-1:0]    init_b;
    logic [W_W-1:0]    init_c;
    logic [CNT_W-1:0]  max_updates;
  } cfg_t;

  typedef struct packed {
    logic [2:0][W_W-1:0] weight;
    logic [CNT_W-1:0]    update_count;
    logic                limit_hit;
    logic                saturated;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/ppt_mul.sv
`default_nettype none

module ppt_mul #(
  parameter int AW = ppt_pkg::MUL_A_W,
  parameter int BW = ppt_pkg::C_W
) (
  input  wire logic                 clk_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0]   p_o
);

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/ppt_seq.sv
`default_nettype none
`include "perceptron_point_trainer_macros.svh"

module ppt_seq #(
  parameter int NUM_WEIGHTS = ppt_pkg::DEF_NUM_WEIGHTS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ppt_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ppt_pkg::item_t in_item_i,
  output logic               fin_valid_o,
  input  wire logic          fin_ready_i,
  output ppt_pkg::res_t      res_o
);

  localparam int IDX_W = $clog2(NUM_WEIGHTS + 1);
  localparam int SEL_W = $clog2(NUM_WEIGHTS);
  localparam int ACC_W = ppt_pkg::PROD_W + $clog2(NUM_WEIGHTS);
  localparam int NOUT  = (NUM_WEIGHTS < 3) ? NUM_WEIGHTS : 3;
  localparam int W_W   = ppt_pkg::W_W;
  localparam int STEP_W = ppt_pkg::STEP_W;
  localparam int PROD_W = ppt_pkg::PROD_W;
  localparam int CNT_W = ppt_pkg::CNT_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_WEIGHTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_STEP = 3'd1;
  localparam logic [2:0] ST_DOT  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   sat_q, sat_d;
  logic                   lim_q, lim_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, acc_sum;
  logic                   label_q;

  logic signed [W_W-1:0]    w_q    [NUM_WEIGHTS];
  logic signed [ppt_pkg::C_W-1:0] coord_q [NUM_WEIGHTS];
  logic signed [STEP_W-1:0] step_q [NUM_WEIGHTS];

  logic signed [ppt_pkg::C_W-1:0] pt     [NUM_WEIGHTS];
  logic signed [W_W-1:0]          init_w [NUM_WEIGHTS];
  logic signed [ppt_pkg::C_W-1:0] in_c3  [3];
  logic signed [W_W-1:0]          init3  [3];

  logic [SEL_W-1:0]              sel, wsel;
  logic signed [ppt_pkg::MUL_A_W-1:0] mul_a;
  logic signed [PROD_W-1:0]      prod, rsum;
  logic signed [STEP_W-1:0]      step_val;
  logic signed [W_W+1:0]         wide;
  logic signed [W_W-1:0]         w_new;
  logic                          clip, wrong;
  logic                          load_in, step_we, w_we;

  // input item and initial weights spread over the weight count
  always_comb begin
    in_c3[0] = $signed(in_item_i.coord_a);
    in_c3[1] = $signed(in_item_i.coord_b);
    in_c3[2] = $signed(in_item_i.coord_c);
    init3[0] = $signed(cfg_i.init_a);
    init3[1] = $signed(cfg_i.init_b);
    init3[2] = $signed(cfg_i.init_c);
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      pt[i]     = '0;
      init_w[i] = '0;
    end
    for (int i = 0; i < NOUT; i++) begin
      pt[i]     = in_c3[i];
      init_w[i] = init3[i];
    end
  end

  assign sel  = (idx_q < LAST) ? idx_q[SEL_W-1:0] : '0;
  assign wsel = SEL_W'(idx_q - IDX_W'(1));

  // shared multiplier: rate times coordinate, then weight times coordinate
  assign mul_a = (state_q == ST_STEP) ?
                 ppt_pkg::MUL_A_W'($signed({1'b0, cfg_i.learn_rate})) :
                 ppt_pkg::MUL_A_W'(w_q[sel]);

  ppt_mul #(
    .AW(ppt_pkg::MUL_A_W),
    .BW(ppt_pkg::C_W)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (coord_q[sel]),
    .p_o  (prod)
  );

  // step rounded half up to q16.16
  assign rsum     = prod + PROD_W'(128);
  assign step_val = rsum[STEP_W+7:8];

  // one weight update with clipping
  always_comb begin
    if (label_q) begin
      wide = {{2{w_q[sel][W_W-1]}}, w_q[sel]} +
             {{(W_W+2-STEP_W){step_q[sel][STEP_W-1]}}, step_q[sel]};
    end else begin
      wide = {{2{w_q[sel][W_W-1]}}, w_q[sel]} -
             {{(W_W+2-STEP_W){step_q[sel][STEP_W-1]}}, step_q[sel]};
    end
    clip  = (wide[W_W+1:W_W-1] != 3'b000) && (wide[W_W+1:W_W-1] != 3'b111);
    w_new = wide[W_W-1:0];
    if (clip) begin
      w_new = wide[W_W+1] ? $signed(ppt_pkg::W_MIN) : $signed(ppt_pkg::W_MAX);
    end
  end

  assign acc_sum = acc_q + ACC_W'(prod);
  assign wrong   = label_q ? acc_sum[ACC_W-1] :
                   (!acc_sum[ACC_W-1] && (acc_sum != '0));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    sat_d   = sat_q;
    lim_d   = lim_q;
    acc_d   = acc_q;
    load_in = 1'b0;
    step_we = 1'b0;
    w_we    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load_in = 1'b1;
          cnt_d   = '0;
          sat_d   = 1'b0;
          lim_d   = 1'b0;
          idx_d   = '0;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        idx_d = idx_q + IDX_W'(1);
        if (idx_q != '0) begin
          step_we = 1'b1;
        end
        if (idx_q == LAST) begin
          idx_d   = '0;
          acc_d   = '0;
          state_d = ST_DOT;
        end
      end
      ST_DOT: begin
        idx_d = idx_q + IDX_W'(1);
        if (idx_q != '0) begin
          acc_d = acc_sum;
        end
        if (idx_q == LAST) begin
          idx_d = '0;
          if (!wrong) begin
            state_d = ST_FIN;
          end else if (cnt_q == cfg_i.max_updates) begin
            lim_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        w_we  = 1'b1;
        sat_d = sat_q | clip;
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == LAST - IDX_W'(1)) begin
          idx_d   = '0;
          acc_d   = '0;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = ST_DOT;
        end
      end
      ST_FIN: begin
        if (fin_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      sat_q   <= 1'b0;
      lim_q   <= 1'b0;
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        w_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      sat_q   <= sat_d;
      lim_q   <= lim_d;
      if (load_in && in_item_i.restart) begin
        for (int i = 0; i < NUM_WEIGHTS; i++) begin
          w_q[i] <= init_w[i];
        end
      end
      if (w_we) begin
        w_q[sel] <= w_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (load_in) begin
      label_q <= in_item_i.label;
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        coord_q[i] <= pt[i];
      end
    end
    if (step_we) begin
      step_q[wsel] <= step_val;
    end
  end

  always_comb begin
    res_o.weight = '0;
    for (int i = 0; i < NOUT; i++) begin
      res_o.weight[i] = w_q[i];
    end
    res_o.update_count = cnt_q;
    res_o.limit_hit    = lim_q;
    res_o.saturated    = sat_q;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign fin_valid_o = (state_q == ST_FIN);

  `PPT_ASSERT_NEVER(a_idx_range, idx_q > LAST, "index counter past weight count")
  `PPT_ASSERT(a_upd_below_max, (state_q == ST_UPD) |-> (cnt_q < cfg_i.max_updates),
              "update started at the update limit")

endmodule

`default_nettype wire

FILE: rtl/perceptron_point_trainer.sv
// Perceptron point trainer. Each input item is one Q8.8 point with a class label; the block
// keeps NUM_WEIGHTS Q16.16 weights and applies rate-scaled add or subtract updates until the
// point lands on its side (or the update limit is hit), then returns the weights, the update
// count and the limit and saturation flags. One shared multiplier does all the work, one
// product per cycle while an item is being worked on. The result sits in an output register, so
// the next item is taken while it waits. Registers are to be written only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
`include "perceptron_point_trainer_macros.svh"

module perceptron_point_trainer #(
  parameter int NUM_WEIGHTS = ppt_pkg::DEF_NUM_WEIGHTS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ppt_pkg::ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [ppt_pkg::W_W-1:0]      cfg_wdata_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [47:0]                  s_axis_tdata,  // coord_a, coord_b, coord_c
  input  wire logic [1:0]                   s_axis_tuser,  // label, restart
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [111:0]                      m_axis_tdata,  // weight_a, weight_b, weight_c,
                                                           // update_count
  output logic [1:0]                        m_axis_tuser   // limit_hit, saturated
);

  ppt_pkg::cfg_t  cfg_q;
  ppt_pkg::item_t item;
  ppt_pkg::res_t  res, out_q;
  logic           out_valid_q;
  logic           fin_valid, fin_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_rate  <= ppt_pkg::RST_LEARN_RATE;
      cfg_q.init_a      <= '0;
      cfg_q.init_b      <= '0;
      cfg_q.init_c      <= '0;
      cfg_q.max_updates <= ppt_pkg::RST_MAX_UPDATES;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ppt_pkg::REG_LEARN_RATE:  cfg_q.learn_rate  <= cfg_wdata_i[ppt_pkg::RATE_W-1:0];
        ppt_pkg::REG_INIT_A:      cfg_q.init_a      <= cfg_wdata_i;
        ppt_pkg::REG_INIT_B:      cfg_q.init_b      <= cfg_wdata_i;
        ppt_pkg::REG_INIT_C:      cfg_q.init_c      <= cfg_wdata_i;
        ppt_pkg::REG_MAX_UPDATES: cfg_q.max_updates <= cfg_wdata_i[ppt_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item.coord_a = s_axis_tdata[15:0];
  assign item.coord_b = s_axis_tdata[31:16];
  assign item.coord_c = s_axis_tdata[47:32];
  assign item.label   = s_axis_tuser[0];
  assign item.restart = s_axis_tuser[1];

  ppt_seq #(
    .NUM_WEIGHTS(NUM_WEIGHTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (item),
    .fin_valid_o(fin_valid),
    .fin_ready_i(fin_ready),
    .res_o      (res)
  );

  // output register
  assign fin_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_valid && fin_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid && fin_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.update_count, out_q.weight[2], out_q.weight[1],
                          out_q.weight[0]};
  assign m_axis_tuser  = {out_q.saturated, out_q.limit_hit};

  `PPT_ASSERT(a_limit_count, (out_valid_q && out_q.limit_hit) |->
              (out_q.update_count == cfg_q.max_updates), "limit flag without full count")

endmodule

`default_nettype wire

FILE: tb/perceptron_point_trainer_tb.sv
`timescale 1ns / 1ps

module perceptron_point_trainer_tb;

  localparam logic [ppt_pkg::ADDR_W-1:0] REG_SPARE = 3'd5;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_AT = 400;
  localparam int HOLD_LEN = 300;
  localparam int RAND_PHASES = 6;
  localparam int RAND_POINTS = 202;
  localparam logic signed [63:0] W_HI = 64'sd2147483647;
  localparam logic signed [63:0] W_LO = -64'sd2147483648;

  typedef struct packed {
    logic [2:0][ppt_pkg::W_W-1:0] wt;
    logic [ppt_pkg::CNT_W-1:0]    updates;
    logic                         limit_hit;
    logic                         saturated;
  } trained_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [ppt_pkg::ADDR_W-1:0] cfg_addr_i = '0;
  logic [ppt_pkg::W_W-1:0] cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;   // coord_a, coord_b, coord_c
  logic [1:0]   s_axis_tuser = '0;   // label, restart
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;        // weight_a, weight_b, weight_c, update_count
  logic [1:0]   m_axis_tuser;        // limit_hit, saturated

  perceptron_point_trainer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state and register copies
  logic [ppt_pkg::RATE_W-1:0] cfg_rate;
  logic [ppt_pkg::W_W-1:0]    cfg_init [3];
  logic [ppt_pkg::CNT_W-1:0]  cfg_max;
  logic signed [ppt_pkg::W_W-1:0] weights_q [3];
  logic signed [63:0]    point_coord [3];

  ppt_pkg::item_t queued_points [$];
  trained_t predicted_weights [$];
  ppt_pkg::item_t next_point;
  trained_t want;
  int       mismatches = 0;
  int       results_seen = 0;
  int       src_gap = 0;
  int       sink_gap = 0;
  int       hold_left = 0;
  logic     hold_armed = 1'b1;
  logic     idle_on = 1'b1;
  int       fld;
  string    wname [3] = '{"weight_a", "weight_b", "weight_c"};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic misplaced(input logic lab);
    logic signed [63:0] dot;
    int i;
    dot = '0;
    for (i = 0; i < 3; i++) dot = dot + weights_q[i] * point_coord[i];
    return lab ? (dot < 0) : (dot > 0);
  endfunction

  function automatic trained_t train_on_point(input logic [47:0] crd_bits, input logic lab,
                                              input logic rst);
    logic signed [63:0] stp [3];
    logic signed [63:0] nw;
    logic [ppt_pkg::CNT_W:0] cnt;
    logic sat;
    trained_t res;
    int i;
    cnt = '0;
    sat = 1'b0;
    for (i = 0; i < 3; i++) begin
      point_coord[i] = {{48{crd_bits[i*ppt_pkg::C_W+ppt_pkg::C_W-1]}},
                        crd_bits[i*ppt_pkg::C_W +: ppt_pkg::C_W]};
      // round half up, floor shift
      stp[i] = ($signed({48'd0, cfg_rate}) * point_coord[i] + 64'sd128) >>> 8;
      if (rst) weights_q[i] = cfg_init[i];
    end
    while (cnt < {1'b0, cfg_max} && misplaced(lab)) begin
      for (i = 0; i < 3; i++) begin
        nw = lab ? weights_q[i] + stp[i] : weights_q[i] - stp[i];
        if (nw > W_HI) begin
          nw = W_HI;
          sat = 1'b1;
        end
        if (nw < W_LO) begin
          nw = W_LO;
          sat = 1'b1;
        end
        weights_q[i] = nw[ppt_pkg::W_W-1:0];
      end
      cnt = cnt + 1'b1;
    end
    for (i = 0; i < 3; i++) res.wt[i] = weights_q[i];
    res.updates = cnt[ppt_pkg::CNT_W-1:0];
    res.limit_hit = misplaced(lab);
    res.saturated = sat;
    return res;
  endfunction

  function automatic void add_point(input logic [ppt_pkg::C_W-1:0] a,
                                    input logic [ppt_pkg::C_W-1:0] b,
                                    input logic [ppt_pkg::C_W-1:0] c, input logic lab,
                                    input logic rst);
    ppt_pkg::item_t p;
    p.coord_a = a;
    p.coord_b = b;
    p.coord_c = c;
    p.label = lab;
    p.restart = rst;
    queued_points.insert(queued_points.size(), p);
  endfunction

  function automatic logic [ppt_pkg::C_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ppt_pkg::W_W-1:0] small_weight();
    logic [31:0] r;
    r = $urandom;
    return {{11{r[20]}}, r[20:0]};
  endfunction

  task automatic write_reg(input logic [ppt_pkg::ADDR_W-1:0] idx,
                           input logic [ppt_pkg::W_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ppt_pkg::REG_LEARN_RATE:  cfg_rate = val[ppt_pkg::RATE_W-1:0];
      ppt_pkg::REG_INIT_A:      cfg_init[0] = val;
      ppt_pkg::REG_INIT_B:      cfg_init[1] = val;
      ppt_pkg::REG_INIT_C:      cfg_init[2] = val;
      ppt_pkg::REG_MAX_UPDATES: cfg_max = val[ppt_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (queued_points.size() != 0 || s_axis_tvalid || predicted_weights.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [ppt_pkg::W_W-1:0] got,
                             input logic [ppt_pkg::W_W-1:0] exp);
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10) $display("%s mismatch: expected %h, got %h", name, exp, got);
    end
  endtask

  // point source
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predicted_weights.insert(predicted_weights.size(),
                                 train_on_point(s_axis_tdata, s_axis_tuser[0],
                                                s_axis_tuser[1]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (idle_on && queued_points.size() != 0 && $urandom_range(0, 5) == 0) begin
          src_gap <= $urandom_range(0, 8);
          s_axis_tvalid <= 1'b0;
        end else if (queued_points.size() != 0) begin
          next_point = queued_points.pop_front();
          s_axis_tdata <= {next_point.coord_c, next_point.coord_b, next_point.coord_a};
          s_axis_tuser <= {next_point.restart, next_point.label};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long hold-off on the result side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && results_seen == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (predicted_weights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h", m_axis_tdata, m_axis_tuser);
      end else begin
        want = predicted_weights.pop_front();
        for (fld = 0; fld < 3; fld++)
          check_field(wname[fld], m_axis_tdata[fld*ppt_pkg::W_W +: ppt_pkg::W_W],
                      want.wt[fld]);
        check_field("update_count", 32'(m_axis_tdata[111:96]), 32'(want.updates));
        check_field("limit_hit", 32'(m_axis_tuser[0]), 32'(want.limit_hit));
        check_field("saturated", 32'(m_axis_tuser[1]), 32'(want.saturated));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[perceptron_point_trainer] ERROR");
    $finish;
  end

  initial begin
    int ph;
    int n;
    int mag;
    logic [ppt_pkg::C_W-1:0] ca;
    cfg_rate = ppt_pkg::RST_LEARN_RATE;
    cfg_max = ppt_pkg::RST_MAX_UPDATES;
    for (n = 0; n < 3; n++) begin
      cfg_init[n] = '0;
      weights_q[n] = '0;
      point_coord[n] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset rate and limit, one seeded weight
    write_reg(ppt_pkg::REG_INIT_A, 32'h0001_0000);
    @(negedge clk_i);
    add_point(-16'sd256, 16'd0, 16'd0, 1'b1, 1'b1);
    add_point(16'sd256, -16'sd512, 16'sd128, 1'b0, 1'b0);
    add_point(16'sd64, 16'sd64, 16'sd64, 1'b1, 1'b0);
    drain();

    // full rate, extreme weights, clipping and limit
    write_reg(ppt_pkg::REG_LEARN_RATE, 32'h0000_ffff);
    write_reg(ppt_pkg::REG_INIT_A, 32'h7fff_ffff);
    write_reg(ppt_pkg::REG_INIT_B, 32'h8000_0000);
    write_reg(ppt_pkg::REG_INIT_C, 32'h0000_0000);
    write_reg(ppt_pkg::REG_MAX_UPDATES, 32'd8);
    write_reg(REG_SPARE, 32'hffff_ffff);
    @(negedge clk_i);
    add_point(16'h7fff, 16'h7fff, 16'h0000, 1'b1, 1'b1);
    add_point(16'h8000, 16'h7fff, 16'h0000, 1'b1, 1'b1);
    add_point(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
    add_point(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    add_point(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0);
    add_point(16'h7fff, 16'hffff, 16'h0001, 1'b0, 1'b1);
    add_point(16'h5555, 16'haaaa, 16'h8001, 1'b1, 1'b0);
    add_point(16'haaaa, 16'h5555, 16'h7ffe, 1'b0, 1'b0);
    add_point(16'h8000, 16'h7fff, 16'h8000, 1'b0, 1'b1);
    drain();

    // zero rate: step vanishes
    write_reg(ppt_pkg::REG_LEARN_RATE, 32'd0);
    write_reg(ppt_pkg::REG_INIT_A, 32'h0100_0000);
    write_reg(ppt_pkg::REG_INIT_B, 32'hff00_0000);
    write_reg(ppt_pkg::REG_INIT_C, 32'h7fff_ffff);
    write_reg(ppt_pkg::REG_MAX_UPDATES, 32'd5);
    @(negedge clk_i);
    add_point(16'sd100, 16'd0, 16'd0, 1'b0, 1'b1);
    add_point(16'd0, 16'sd300, 16'd0, 1'b0, 1'b1);
    add_point(-16'sd1, 16'd0, 16'd0, 1'b1, 1'b0);
    drain();

    // no updates allowed
    write_reg(ppt_pkg::REG_LEARN_RATE, 32'd6554);
    write_reg(ppt_pkg::REG_MAX_UPDATES, 32'd0);
    @(negedge clk_i);
    add_point(16'sd100, 16'd0, 16'd0, 1'b0, 1'b1);
    add_point(16'sd100, 16'd0, 16'd0, 1'b1, 1'b1);
    add_point(16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
    drain();

    // step rounds to zero on tiny coordinates
    write_reg(ppt_pkg::REG_LEARN_RATE, 32'd1);
    write_reg(ppt_pkg::REG_INIT_A, 32'h0001_0000);
    write_reg(ppt_pkg::REG_MAX_UPDATES, 32'd3);
    @(negedge clk_i);
    add_point(16'sd1, -16'sd1, 16'sd2, 1'b0, 1'b1);
    add_point(-16'sd2, 16'sd1, 16'sd1, 1'b1, 1'b0);
    drain();

    // largest limit, points that converge quickly
    write_reg(ppt_pkg::REG_LEARN_RATE, 32'h0000_ffff);
    write_reg(ppt_pkg::REG_INIT_A, small_weight());
    write_reg(ppt_pkg::REG_INIT_B, small_weight());
    write_reg(ppt_pkg::REG_INIT_C, small_weight());
    write_reg(ppt_pkg::REG_MAX_UPDATES, 32'h0000_ffff);
    @(negedge clk_i);
    add_point(16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
    for (n = 0; n < 19; n++) begin
      mag = $urandom_range(4096, 32767);
      ca = mag[ppt_pkg::C_W-1:0];
      if ($urandom_range(0, 1) != 0) ca = -ca;
      add_point(ca, 16'($urandom), 16'($urandom), 1'($urandom), 1'b1);
    end
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(ppt_pkg::REG_LEARN_RATE, ph == 0 ? 32'd0 : ph == 1 ? 32'h0000_ffff
                                                 : 32'($urandom_range(1, 65535)));
      write_reg(ppt_pkg::REG_INIT_A, ph[0] ? $urandom : small_weight());
      write_reg(ppt_pkg::REG_INIT_B, ph[0] ? $urandom : small_weight());
      write_reg(ppt_pkg::REG_INIT_C, ph[0] ? $urandom : small_weight());
      write_reg(ppt_pkg::REG_MAX_UPDATES, ph == 2 ? 32'd1 : 32'($urandom_range(1, 16)));
      @(negedge clk_i);
      // quiet handshakes in the last stretch
      idle_on <= (ph != RAND_PHASES - 1);
      for (n = 0; n < RAND_POINTS; n++)
        add_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom),
                  $urandom_range(0, 3) == 0);
      drain();
    end

    if (mismatches == 0 && predicted_weights.size() == 0) begin
      $display("[perceptron_point_trainer] OK");
    end else begin
      $display("[perceptron_point_trainer] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ppt_pkg.sv
rtl/ppt_mul.sv
rtl/ppt_seq.sv
rtl/perceptron_point_trainer.sv
tb/perceptron_point_trainer_tb.sv
